// ----- src/tfg_pkg.sv -----
// shared types, codes and helpers of the trigger fanout gate
package tfg_pkg;

    // table depth and density scale
    localparam int unsigned TABLE_SIZE    = 8;
    localparam int unsigned DENSITY_SCALE = 100;

    // item kinds
    localparam logic [2:0] KIND_TRIGGER    = 3'd0;
    localparam logic [2:0] KIND_SET_ENABLE = 3'd1;
    localparam logic [2:0] KIND_SET_CTRL   = 3'd2;
    localparam logic [2:0] KIND_CLEAR      = 3'd3;
    localparam logic [2:0] KIND_DISABLE    = 3'd4;

    // gate modes
    localparam logic [1:0] GATE_HOLDOFF = 2'd0;
    localparam logic [1:0] GATE_SKIP    = 2'd1;
    localparam logic [1:0] GATE_DENSITY = 2'd2;
    localparam logic [1:0] GATE_INVALID = 2'd3;

    // configuration register indexes
    localparam logic CFG_OUTPUT_MODE_ON = 1'b0;
    localparam logic CFG_RANDOM_SEED    = 1'b1;

    // reset values
    localparam logic        MODE_ON_RESET = 1'b1;
    localparam logic [15:0] SEED_RESET    = 16'd44257;

    // galois lfsr feedback
    localparam logic [15:0] LFSR_TAPS = 16'hB400;

    // x div 100 as (x >> 2) div 25: floor((x >> 2) * 41944 / 2^20) is exact for 16-bit x
    localparam logic [15:0] MOD_RECIP = 16'd41944;
    localparam int unsigned MOD_SHIFT = 20;

    // input beat
    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] now_ms;
        logic [2:0]  channel_index;
        logic        enable_value;
        logic [1:0]  gate_mode;
        logic [15:0] ctrl_value;
    } t_in_item;

    // result beat
    typedef struct packed {
        logic [7:0] fire_mask;
        logic       mode_error;
        logic       active;
    } t_out_item;

    // per-lane control strobes, already qualified by input accept
    typedef struct packed {
        logic trig;
        logic set_ctrl;
    } t_lane_ctl;

    // per-lane status
    typedef struct packed {
        logic [1:0]  mode;
        logic        fire;
        logic [15:0] value;
    } t_lane_stat;

    // one right shift of the lfsr
    function automatic logic [15:0] lfsr_step(input logic [15:0] w);
        logic [15:0] s;
        s = {1'b0, w[15:1]};
        return w[0] ? (s ^ LFSR_TAPS) : s;
    endfunction

endpackage

// ----- src/tfg_lane.sv -----
// one output channel: gate tables, holdoff and skip decisions
module tfg_lane (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  tfg_pkg::t_lane_ctl    i_ctl,
    input  logic [31:0]           i_now_ms,
    input  logic [1:0]            i_gate_mode,
    input  logic [15:0]           i_ctrl_value,
    output tfg_pkg::t_lane_stat   o_stat
);

    logic [1:0]  r_mode;
    logic [15:0] r_value;
    logic [31:0] r_blank;
    logic [16:0] r_skip;

    logic hold_hit;
    logic skip_hit;

    // gate compares against current table entries
    assign hold_hit = i_now_ms > r_blank;
    assign skip_hit = r_skip > {1'b0, r_value};

    always_comb begin
        o_stat.mode  = r_mode;
        o_stat.value = r_value;
        o_stat.fire  = ((r_mode == tfg_pkg::GATE_HOLDOFF) && hold_hit) ||
                       ((r_mode == tfg_pkg::GATE_SKIP) && skip_hit);
    end

    // table update on set control or routed trigger
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= tfg_pkg::GATE_HOLDOFF;
            r_value <= '0;
            r_blank <= '0;
            r_skip  <= '0;
        end else if (i_ctl.set_ctrl) begin
            r_mode  <= i_gate_mode;
            r_value <= i_ctrl_value;
            r_blank <= i_now_ms + {16'd0, i_ctrl_value};
        end else if (i_ctl.trig) begin
            unique case (r_mode)
                tfg_pkg::GATE_HOLDOFF: begin
                    if (hold_hit) begin
                        r_blank <= i_now_ms + {16'd0, r_value};
                    end
                end
                tfg_pkg::GATE_SKIP: begin
                    r_skip <= skip_hit ? 17'd0 : r_skip + 17'd1;
                end
                default: begin
                end
            endcase
        end
    end

endmodule

// ----- src/tfg_draw.sv -----
// density decision: draw mod 100 compared against 100 minus the percent
module tfg_draw (
    input  logic [15:0] i_draw,
    input  logic [15:0] i_value,
    output logic        o_hit
);

    logic [29:0] prod;
    logic [9:0]  quot;
    logic [16:0] quot_x100;
    logic [16:0] rem_full;
    logic [6:0]  rem;
    logic [16:0] sum;

    // remainder by reciprocal multiply on the draw over four, quotient times 100 as shifts
    assign prod      = i_draw[15:2] * tfg_pkg::MOD_RECIP;
    assign quot      = prod[29:tfg_pkg::MOD_SHIFT];
    assign quot_x100 = {1'b0, quot, 6'd0} + {2'b0, quot, 5'd0} + {5'b0, quot, 2'd0};
    assign rem_full  = {1'b0, i_draw} - quot_x100;
    assign rem       = rem_full[6:0];

    // r > 100 - v signed is the same as r + v > 100 unsigned
    assign sum   = {10'd0, rem} + {1'b0, i_value};
    assign o_hit = sum > 17'(tfg_pkg::DENSITY_SCALE);

endmodule

// ----- src/trigger_fanout_gate_unit.sv -----
// Trigger fanout gate: routes trigger beats to up to eight gated outputs.
// One beat is accepted per clock; its result passes the stage register, whose
// load updates the active flag, enable mask, per-output tables and the density
// lfsr and registers the draws, then the result register, loaded after each
// draw is reduced mod 100 in a multiplier per output. Sustained rate is one
// beat per cycle; a stalled result holds the stage register, after which the
// input side stalls. Configuration writes take effect on the next cycle; a seed
// write reloads the lfsr and wins over the update by a beat accepted with it.
module trigger_fanout_gate_unit #(
    parameter int unsigned OUTPUT_COUNT = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  tfg_pkg::t_in_item   i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output tfg_pkg::t_out_item  o_out_item,
    input  logic                i_cfg_we,
    input  logic                i_cfg_index,
    input  logic [15:0]         i_cfg_data
);

    localparam int unsigned LANES =
        (OUTPUT_COUNT < tfg_pkg::TABLE_SIZE) ? OUTPUT_COUNT : tfg_pkg::TABLE_SIZE;
    localparam int unsigned TS = tfg_pkg::TABLE_SIZE;

    // control state
    logic        r_mode_on;
    logic [15:0] r_lfsr;
    logic        r_active;
    logic [7:0]  r_enable;

    // stage register
    logic        r_s1_valid;
    logic [7:0]  r_s1_fire;
    logic [7:0]  r_s1_dens;
    logic [15:0] r_s1_draw [TS];
    logic [15:0] r_s1_val  [TS];
    logic        r_s1_err;
    logic        r_s1_active;

    // result register
    logic                r_out_valid;
    tfg_pkg::t_out_item  r_out_item;

    logic accept;
    logic adv_out;
    logic trig_route;
    logic ch_ok;

    tfg_pkg::t_lane_ctl  lane_ctl  [TS];
    tfg_pkg::t_lane_stat lane_stat [TS];

    logic [7:0]  n_enable;
    logic        n_active;
    logic [15:0] n_lfsr;
    logic [7:0]  n_fire;
    logic [7:0]  n_dens;
    logic [15:0] n_draw [TS];
    logic        n_err;
    logic [7:0]  dens_hit;

    // handshake
    assign adv_out    = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_s1_valid && !adv_out;
    assign accept     = i_in_valid && !o_in_stall;

    assign trig_route = accept && (i_in_item.kind == tfg_pkg::KIND_TRIGGER) && r_mode_on;
    assign ch_ok      = 32'(i_in_item.channel_index) < LANES;

    // output lanes
    for (genvar g = 0; g < TS; g++) begin : g_lane
        if (g < LANES) begin : g_on
            assign lane_ctl[g].trig     = trig_route && r_enable[g];
            assign lane_ctl[g].set_ctrl = accept &&
                (i_in_item.kind == tfg_pkg::KIND_SET_CTRL) &&
                (i_in_item.channel_index == 3'(g));
            tfg_lane u_lane (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctl        (lane_ctl[g]),
                .i_now_ms     (i_in_item.now_ms),
                .i_gate_mode  (i_in_item.gate_mode),
                .i_ctrl_value (i_in_item.ctrl_value),
                .o_stat       (lane_stat[g])
            );
        end else begin : g_off
            assign lane_ctl[g]  = '0;
            assign lane_stat[g] = '0;
        end
    end

    // gate decisions and lfsr chain, one step per routed density output
    always_comb begin
        logic [15:0] w;
        w      = r_lfsr;
        n_fire = '0;
        n_dens = '0;
        n_err  = 1'b0;
        for (int i = 0; i < TS; i++) begin
            if (lane_ctl[i].trig && (lane_stat[i].mode == tfg_pkg::GATE_DENSITY)) begin
                w         = tfg_pkg::lfsr_step(w);
                n_dens[i] = 1'b1;
            end
            n_draw[i] = w;
            if (lane_ctl[i].trig && lane_stat[i].fire) begin
                n_fire[i] = 1'b1;
            end
            if (lane_ctl[i].trig && (lane_stat[i].mode == tfg_pkg::GATE_INVALID)) begin
                n_err = 1'b1;
            end
        end
        n_lfsr = w;

        // enable mask and active flag
        n_enable = r_enable;
        n_active = r_active;
        unique case (i_in_item.kind)
            tfg_pkg::KIND_TRIGGER: begin
                n_active = !r_active;
            end
            tfg_pkg::KIND_SET_ENABLE: begin
                if (ch_ok) begin
                    n_enable[i_in_item.channel_index] = i_in_item.enable_value;
                    if (r_active) begin
                        n_fire[i_in_item.channel_index] = 1'b1;
                    end
                    if (n_enable == 8'd0) begin
                        n_active = 1'b0;
                    end
                end
            end
            tfg_pkg::KIND_CLEAR: begin
                n_active = 1'b0;
            end
            tfg_pkg::KIND_DISABLE: begin
                n_enable = '0;
            end
            default: begin
            end
        endcase
    end

    // control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode_on <= tfg_pkg::MODE_ON_RESET;
            r_lfsr    <= tfg_pkg::SEED_RESET;
            r_active  <= 1'b0;
            r_enable  <= '0;
        end else begin
            if (accept) begin
                r_active <= n_active;
                r_enable <= n_enable;
                r_lfsr   <= n_lfsr;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    tfg_pkg::CFG_OUTPUT_MODE_ON: r_mode_on <= i_cfg_data[0];
                    tfg_pkg::CFG_RANDOM_SEED: begin
                        r_lfsr <= (i_cfg_data == 16'd0) ? 16'd1 : i_cfg_data;
                    end
                endcase
            end
        end
    end

    // stage register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (adv_out) begin
            r_s1_valid <= 1'b0;
        end
    end

    // stage register payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_fire   <= n_fire;
            r_s1_dens   <= n_dens;
            r_s1_err    <= n_err;
            r_s1_active <= n_active;
            for (int i = 0; i < TS; i++) begin
                r_s1_draw[i] <= n_draw[i];
                r_s1_val[i]  <= lane_stat[i].value;
            end
        end
    end

    // density compares in the result stage
    for (genvar g = 0; g < TS; g++) begin : g_draw
        tfg_draw u_draw (
            .i_draw  (r_s1_draw[g]),
            .i_value (r_s1_val[g]),
            .o_hit   (dens_hit[g])
        );
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv_out) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_out && r_s1_valid) begin
            r_out_item.fire_mask  <= r_s1_fire | (r_s1_dens & dens_hit);
            r_out_item.mode_error <= r_s1_err;
            r_out_item.active     <= r_s1_active;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// ----- src/tfg_checker.sv -----
// port-level checks of the trigger fanout gate and their binding
module tfg_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input tfg_pkg::t_out_item  o_out_item
);

    // reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result beat changed");

    // every accepted beat reaches the result side once past the stage register
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |-> ##2 o_out_valid)
        else $error("accepted beat did not reach result register");

    // input side only stalls behind a waiting result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("input stalled with empty result register");

endmodule

bind trigger_fanout_gate_unit tfg_checker u_tfg_checker (.*);

// ----- tb/tb_trigger_fanout_gate_unit.sv -----
// self-checking testbench of the trigger fanout gate unit
`timescale 1ns / 100ps
module tb_trigger_fanout_gate_unit;

    localparam int CHANNELS    = 8;
    localparam int CYCLE_LIMIT = 300000;
    localparam int REPORT_MAX  = 10;
    localparam int HOLD_CYCLES = 200;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic                o_in_stall;
    tfg_pkg::t_in_item   i_in_item   = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    tfg_pkg::t_out_item  o_out_item;
    logic                i_cfg_we    = 1'b0;
    logic                i_cfg_index = 1'b0;
    logic [15:0]         i_cfg_data  = '0;

    trigger_fanout_gate_unit #(.OUTPUT_COUNT(CHANNELS)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // shadow copy of the gate state and configuration
    logic        route_on;
    logic [15:0] prng_q;
    logic        active_q;
    logic [7:0]  enable_q;
    logic [1:0]  gate_q  [CHANNELS];
    logic [15:0] limit_q [CHANNELS];
    logic [31:0] blank_q [CHANNELS];
    logic [16:0] skip_q  [CHANNELS];

    tfg_pkg::t_out_item pending_fanouts [$];
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          fail_count    = 0;
    int          cycles        = 0;
    int          hold_left     = 0;
    logic        hold_start    = 1'b0;
    logic [31:0] clock_ms      = '0;

    // zero seed is promoted to one so the lfsr never locks up
    function automatic void load_prng(logic [15:0] seed);
        prng_q = (seed == 16'd0) ? 16'd1 : seed;
    endfunction

    function automatic void reset_shadow();
        route_on = tfg_pkg::MODE_ON_RESET;
        load_prng(tfg_pkg::SEED_RESET);
        active_q = 1'b0;
        enable_q = '0;
        for (int i = 0; i < CHANNELS; i++) begin
            gate_q[i]  = tfg_pkg::GATE_HOLDOFF;
            limit_q[i] = '0;
            blank_q[i] = '0;
            skip_q[i]  = '0;
        end
    endfunction

    // expected result of one beat, advancing the shadow state
    function automatic tfg_pkg::t_out_item predict_fanout(tfg_pkg::t_in_item b);
        tfg_pkg::t_out_item r;
        logic [16:0]        prior;
        int                 draw;
        r = '0;
        case (b.kind)
            tfg_pkg::KIND_TRIGGER: begin
                active_q = ~active_q;
                if (route_on) begin
                    for (int i = 0; i < CHANNELS; i++) begin
                        if (enable_q[i]) begin
                            case (gate_q[i])
                                tfg_pkg::GATE_HOLDOFF: begin
                                    if (b.now_ms > blank_q[i]) begin
                                        r.fire_mask[i] = 1'b1;
                                        blank_q[i] = b.now_ms + 32'(limit_q[i]);
                                    end
                                end
                                tfg_pkg::GATE_SKIP: begin
                                    prior = skip_q[i];
                                    skip_q[i] = prior + 17'd1;
                                    if (prior > {1'b0, limit_q[i]}) begin
                                        r.fire_mask[i] = 1'b1;
                                        skip_q[i] = '0;
                                    end
                                end
                                tfg_pkg::GATE_DENSITY: begin
                                    // lfsr steps before the draw; signed compare
                                    prng_q = (prng_q >> 1) ^
                                             (prng_q[0] ? tfg_pkg::LFSR_TAPS : 16'h0000);
                                    draw = int'(prng_q % tfg_pkg::DENSITY_SCALE);
                                    if (draw > int'(tfg_pkg::DENSITY_SCALE) -
                                               int'(limit_q[i]))
                                        r.fire_mask[i] = 1'b1;
                                end
                                default: begin
                                    r.mode_error = 1'b1;
                                end
                            endcase
                        end
                    end
                end
            end
            tfg_pkg::KIND_SET_ENABLE: begin
                enable_q[b.channel_index] = b.enable_value;
                if (active_q)
                    r.fire_mask[b.channel_index] = 1'b1;
                if (enable_q == '0)
                    active_q = 1'b0;
            end
            tfg_pkg::KIND_SET_CTRL: begin
                gate_q[b.channel_index]  = b.gate_mode;
                limit_q[b.channel_index] = b.ctrl_value;
                blank_q[b.channel_index] = b.now_ms + 32'(b.ctrl_value);
            end
            tfg_pkg::KIND_CLEAR: begin
                active_q = 1'b0;
            end
            tfg_pkg::KIND_DISABLE: begin
                enable_q = '0;
            end
            default: begin
            end
        endcase
        r.active = active_q;
        return r;
    endfunction

    function automatic tfg_pkg::t_in_item make_beat(logic [2:0] kind, logic [31:0] now,
                                                    logic [2:0] ch, logic en,
                                                    logic [1:0] mode, logic [15:0] val);
        tfg_pkg::t_in_item b;
        b.kind          = kind;
        b.now_ms        = now;
        b.channel_index = ch;
        b.enable_value  = en;
        b.gate_mode     = mode;
        b.ctrl_value    = val;
        return b;
    endfunction

    // random beat: triggers most often, on a slowly advancing time base
    function automatic tfg_pkg::t_in_item pick_random_beat();
        tfg_pkg::t_in_item b;
        int                roll;
        roll = $urandom_range(0, 99);
        if (roll < 45)      b.kind = tfg_pkg::KIND_TRIGGER;
        else if (roll < 65) b.kind = tfg_pkg::KIND_SET_ENABLE;
        else if (roll < 85) b.kind = tfg_pkg::KIND_SET_CTRL;
        else if (roll < 90) b.kind = tfg_pkg::KIND_CLEAR;
        else if (roll < 95) b.kind = tfg_pkg::KIND_DISABLE;
        else                b.kind = tfg_pkg::KIND_DISABLE + 3'($urandom_range(1, 3));
        // occasional jump anywhere, wrap included
        if ($urandom_range(0, 19) == 0)
            clock_ms = $urandom;
        else
            clock_ms = clock_ms + 32'($urandom_range(0, 40));
        b.now_ms        = clock_ms;
        b.channel_index = 3'($urandom_range(0, CHANNELS - 1));
        b.enable_value  = ($urandom_range(0, 9) < 7);
        roll = $urandom_range(0, 99);
        if (roll < 30)      b.gate_mode = tfg_pkg::GATE_HOLDOFF;
        else if (roll < 60) b.gate_mode = tfg_pkg::GATE_SKIP;
        else if (roll < 90) b.gate_mode = tfg_pkg::GATE_DENSITY;
        else                b.gate_mode = tfg_pkg::GATE_INVALID;
        case (b.gate_mode)
            tfg_pkg::GATE_HOLDOFF: b.ctrl_value = 16'($urandom_range(0, 60));
            tfg_pkg::GATE_SKIP:    b.ctrl_value = 16'($urandom_range(0, 6));
            default:               b.ctrl_value = 16'($urandom_range(0, 120));
        endcase
        if ($urandom_range(0, 9) == 0)
            b.ctrl_value = 16'($urandom);
        return b;
    endfunction

    // offer one beat, with random gaps ahead of it, and hold until taken
    task automatic send_beat(tfg_pkg::t_in_item b);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pending_fanouts.push_back(predict_fanout(b));
    endtask

    // drain every pending result, then let the pipeline settle
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_fanouts.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [15:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == tfg_pkg::CFG_OUTPUT_MODE_ON)
            route_on = data[0];
        else
            load_prng(data);
        @(posedge i_clk);
    endtask

    // result side: check each beat, then pick the stall for the next cycle
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            check_fanout(o_out_item);
        if (hold_start) begin
            hold_start  <= 1'b0;
            hold_left   <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    task automatic check_fanout(tfg_pkg::t_out_item got);
        tfg_pkg::t_out_item want;
        if (pending_fanouts.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_MAX)
                $display("%0t: result beat with nothing pending: %p", $time, got);
        end else begin
            want = pending_fanouts.pop_front();
            if (got.fire_mask !== want.fire_mask || got.mode_error !== want.mode_error ||
                got.active !== want.active) begin
                fail_count++;
                if (fail_count <= REPORT_MAX)
                    $display("%0t: expected fire %h err %b active %b, got fire %h err %b active %b",
                             $time, want.fire_mask, want.mode_error, want.active,
                             got.fire_mask, got.mode_error, got.active);
            end
        end
    endtask

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // extremes of every field, every kind and each corner of the gates
    task automatic test_directed();
        send_idle_pct = 20;
        recv_idle_pct = 20;
        // trigger with nothing enabled only toggles active
        send_beat(make_beat(tfg_pkg::KIND_TRIGGER, 32'd0, 3'd0, 1'b0,
                            tfg_pkg::GATE_HOLDOFF, 16'd0));
        // unused kind code with every other field at its top
        send_beat(make_beat(tfg_pkg::KIND_DISABLE + 3'd3, '1, 3'd7, 1'b1,
                            tfg_pkg::GATE_INVALID, 16'hFFFF));
        // enable while active pulses that output
        send_beat(make_beat(tfg_pkg::KIND_SET_ENABLE, 32'd0, 3'd0, 1'b1,
                            tfg_pkg::GATE_HOLDOFF, 16'd0));
        // holdoff with blanking time wrapping past 2^32
        send_beat(make_beat(tfg_pkg::KIND_SET_CTRL, '1, 3'd0, 1'b0,
                            tfg_pkg::GATE_HOLDOFF, 16'hFFFF));
        send_beat(make_beat(tfg_pkg::KIND_TRIGGER, '1, 3'd0, 1'b0,
                            tfg_pkg::GATE_HOLDOFF, 16'd0));
        send_beat(make_beat(tfg_pkg::KIND_TRIGGER, 32'd0, 3'd0, 1'b0,
                            tfg_pkg::GATE_HOLDOFF, 16'd0));
        // skip with zero count on the top channel
        send_beat(make_beat(tfg_pkg::KIND_SET_CTRL, 32'd0, 3'd7, 1'b0,
                            tfg_pkg::GATE_SKIP, 16'd0));
        send_beat(make_beat(tfg_pkg::KIND_SET_ENABLE, 32'd0, 3'd7, 1'b1,
                            tfg_pkg::GATE_HOLDOFF, 16'd0));
        repeat (3) send_beat(make_beat(tfg_pkg::KIND_TRIGGER, 32'd1, 3'd0, 1'b0,
                                       tfg_pkg::GATE_HOLDOFF, 16'd0));
        // density beyond 100 percent: limit goes negative, always fires
        send_beat(make_beat(tfg_pkg::KIND_SET_CTRL, 32'd5, 3'd3, 1'b0,
                            tfg_pkg::GATE_DENSITY, 16'hFFFF));
        send_beat(make_beat(tfg_pkg::KIND_SET_ENABLE, 32'd5, 3'd3, 1'b1,
                            tfg_pkg::GATE_HOLDOFF, 16'd0));
        send_beat(make_beat(tfg_pkg::KIND_TRIGGER, 32'd6, 3'd0, 1'b0,
                            tfg_pkg::GATE_HOLDOFF, 16'd0));
        // zero density never fires
        send_beat(make_beat(tfg_pkg::KIND_SET_CTRL, 32'd6, 3'd3, 1'b0,
                            tfg_pkg::GATE_DENSITY, 16'd0));
        send_beat(make_beat(tfg_pkg::KIND_TRIGGER, 32'd7, 3'd0, 1'b0,
                            tfg_pkg::GATE_HOLDOFF, 16'd0));
        // invalid mode raises the error flag
        send_beat(make_beat(tfg_pkg::KIND_SET_CTRL, 32'd7, 3'd5, 1'b0,
                            tfg_pkg::GATE_INVALID, 16'd0));
        send_beat(make_beat(tfg_pkg::KIND_SET_ENABLE, 32'd7, 3'd5, 1'b1,
                            tfg_pkg::GATE_HOLDOFF, 16'd0));
        send_beat(make_beat(tfg_pkg::KIND_TRIGGER, 32'd8, 3'd0, 1'b0,
                            tfg_pkg::GATE_HOLDOFF, 16'd0));
        // clear drops active, then disable all leaves active unchanged
        send_beat(make_beat(tfg_pkg::KIND_CLEAR, 32'd8, 3'd0, 1'b0,
                            tfg_pkg::GATE_HOLDOFF, 16'd0));
        send_beat(make_beat(tfg_pkg::KIND_DISABLE, 32'd8, 3'd0, 1'b0,
                            tfg_pkg::GATE_HOLDOFF, 16'd0));
        send_beat(make_beat(tfg_pkg::KIND_TRIGGER, 32'd9, 3'd0, 1'b0,
                            tfg_pkg::GATE_HOLDOFF, 16'd0));
        // disabling with the mask already empty pulses and then drops active
        send_beat(make_beat(tfg_pkg::KIND_SET_ENABLE, 32'd9, 3'd2, 1'b0,
                            tfg_pkg::GATE_HOLDOFF, 16'd0));
        send_beat(make_beat(tfg_pkg::KIND_DISABLE + 3'd1, 32'd9, 3'd1, 1'b1,
                            tfg_pkg::GATE_SKIP, 16'd1));
        send_beat(make_beat(tfg_pkg::KIND_DISABLE + 3'd2, 32'd9, 3'd4, 1'b0,
                            tfg_pkg::GATE_DENSITY, 16'd2));
        wait_idle();
    endtask

    // triggers with output routing off only toggle active
    task automatic test_output_mode_off();
        write_reg(tfg_pkg::CFG_OUTPUT_MODE_ON, 16'h0000);
        send_idle_pct = 10;
        recv_idle_pct = 10;
        repeat (30) send_beat(pick_random_beat());
        wait_idle();
        write_reg(tfg_pkg::CFG_OUTPUT_MODE_ON, 16'h0001);
    endtask

    task automatic test_random_traffic(int beats, int send_pct, int recv_pct,
                                       logic [15:0] seed);
        tfg_pkg::t_in_item b;
        int                sent;
        write_reg(tfg_pkg::CFG_RANDOM_SEED, seed);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        sent = 0;
        while (sent < beats) begin
            b = pick_random_beat();
            send_beat(b);
            if (b.kind <= tfg_pkg::KIND_DISABLE)
                sent++;
        end
        wait_idle();
    endtask

    // long receiver hold while the sender keeps offering beats
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_start <= 1'b1;
        repeat (40) send_beat(pick_random_beat());
        wait_idle();
    endtask

    initial begin
        reset_shadow();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_output_mode_off();
        test_random_traffic(160, 38, 79, 16'h0000);
        test_random_traffic(160, 79, 38, 16'hFFFF);
        test_random_traffic(150, 0, 0, 16'($urandom_range(1, 65535)));
        test_backpressure();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
